[sv/lbzr_pkg.sv]
// Shared types and constants of the low-pass / zero-reject filter core.
// Used by lbzr_cmul, lbzr_front, lbzr_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package lbzr_pkg;

  localparam int DATA_WIDTH_DEF     = 32;
  localparam int COEF_FRAC_BITS_DEF = 30;
  localparam int COEF_WIDTH         = 32;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic signed [COEF_WIDTH-1:0] INPUT_SCALE_RST  = 32'sd11201730;
  localparam logic signed [COEF_WIDTH-1:0] FEEDBACK_ONE_RST = 32'sd1815693534;
  localparam logic signed [COEF_WIDTH-1:0] FEEDBACK_TWO_RST = -32'sd786758582;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FILTER_MODE  = 2'd0,
    REG_INPUT_SCALE  = 2'd1,
    REG_FEEDBACK_ONE = 2'd2,
    REG_FEEDBACK_TWO = 2'd3
  } reg_idx_t;

  typedef enum logic {
    MODE_LOWPASS     = 1'b0,
    MODE_ZERO_REJECT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    OP_LOWPASS  = 2'd0,
    OP_HOLD_SET = 2'd1,
    OP_NONE     = 2'd2,
    OP_EMPTY    = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } cmd_t;

endpackage

[sv/lbzr_cmul.sv]
// Coefficient multiplier: data times Q-format coefficient, rounded to nearest
// (ties away from zero) and saturated to the data width. Uses lbzr_pkg.
`timescale 1ns / 1ps

module lbzr_cmul #(
  parameter int DATA_WIDTH     = lbzr_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = lbzr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic signed [DATA_WIDTH-1:0]           data_i,
  input  logic signed [lbzr_pkg::COEF_WIDTH-1:0] coef_i,
  output logic signed [DATA_WIDTH-1:0]           prod_o
);

  localparam int PW = DATA_WIDTH + lbzr_pkg::COEF_WIDTH;
  localparam logic [PW:0] RND  = (PW+1)'(1) << (COEF_FRAC_BITS - 1);
  localparam logic [PW:0] HALF = (PW+1)'(1) << (DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] prod;
  logic        [PW-1:0] mag;
  logic        [PW:0]   rnd;
  logic        [PW:0]   shf;
  logic                 neg;

  assign prod = $signed(data_i) * $signed(coef_i);
  assign neg  = prod[PW-1];
  assign mag  = neg ? (~prod + PW'(1)) : prod;
  assign rnd  = {1'b0, mag} + RND;
  assign shf  = rnd >> COEF_FRAC_BITS;

  always_comb begin
    if (shf >= HALF) begin
      prod_o = neg ? DMIN : DMAX;
    end else if (neg) begin
      prod_o = -$signed(shf[DATA_WIDTH-1:0]);
    end else begin
      prod_o = $signed(shf[DATA_WIDTH-1:0]);
    end
  end

endmodule

[sv/lbzr_queue.sv]
// Short register queue between the front and back parts of the filter.
// Generic payload; depth a power of two. Depends on nothing.
`timescale 1ns / 1ps

module lbzr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign head_o  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_i  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

[sv/lbzr_front.sv]
// Front part: configuration registers, input scaling, batch tracking and
// zero-reject selection; emits one command per item. Uses lbzr_pkg, lbzr_cmul.
`timescale 1ns / 1ps

module lbzr_front #(
  parameter int DATA_WIDTH     = lbzr_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = lbzr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic signed [DATA_WIDTH-1:0]               sample_i,
  input  logic                                       last_i,
  input  logic                                       empty_i,
  input  logic                                       cfg_wr_en_i,
  input  logic [lbzr_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index_i,
  input  logic [lbzr_pkg::COEF_WIDTH-1:0]            cfg_wdata_i,
  input  logic                                       q_full_i,
  output logic                                       push_o,
  output lbzr_pkg::cmd_t                             push_cmd_o,
  output logic signed [DATA_WIDTH-1:0]               push_value_o,
  output logic signed [lbzr_pkg::COEF_WIDTH-1:0]     feedback_one_o,
  output logic signed [lbzr_pkg::COEF_WIDTH-1:0]     feedback_two_o
);

  lbzr_pkg::mode_t                         mode_r;
  logic signed [lbzr_pkg::COEF_WIDTH-1:0]  scale_r;
  logic signed [lbzr_pkg::COEF_WIDTH-1:0]  fb_one_r;
  logic signed [lbzr_pkg::COEF_WIDTH-1:0]  fb_two_r;
  logic signed [DATA_WIDTH-1:0]            prev_first_r, prev_first_nxt;
  logic                                    at_start_r, at_start_nxt;
  logic signed [DATA_WIDTH-1:0]            scaled;
  logic                                    accept;

  assign in_ready_o     = !q_full_i;
  assign accept         = in_valid_i && in_ready_o;
  assign push_o         = accept;
  assign feedback_one_o = fb_one_r;
  assign feedback_two_o = fb_two_r;

  lbzr_cmul #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_scale (
    .data_i (sample_i),
    .coef_i (scale_r),
    .prod_o (scaled)
  );

  // classify the item
  always_comb begin
    prev_first_nxt  = prev_first_r;
    at_start_nxt    = at_start_r;
    push_cmd_o.last = last_i;
    push_cmd_o.op   = lbzr_pkg::OP_NONE;
    push_value_o    = sample_i;
    if (empty_i) begin
      push_cmd_o.op = lbzr_pkg::OP_EMPTY;
    end else if (mode_r == lbzr_pkg::MODE_LOWPASS) begin
      push_cmd_o.op = lbzr_pkg::OP_LOWPASS;
      push_value_o  = scaled;
    end else if (at_start_r) begin
      push_cmd_o.op  = lbzr_pkg::OP_HOLD_SET;
      push_value_o   = (sample_i != '0) ? sample_i : prev_first_r;
      prev_first_nxt = sample_i;
    end
    if (accept) begin
      at_start_nxt = empty_i ? 1'b1 : last_i;
    end
    if (!accept) begin
      prev_first_nxt = prev_first_r;
    end
    if (cfg_wr_en_i && (lbzr_pkg::reg_idx_t'(cfg_index_i) == lbzr_pkg::REG_FILTER_MODE)) begin
      prev_first_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= lbzr_pkg::MODE_LOWPASS;
      scale_r      <= lbzr_pkg::INPUT_SCALE_RST;
      fb_one_r     <= lbzr_pkg::FEEDBACK_ONE_RST;
      fb_two_r     <= lbzr_pkg::FEEDBACK_TWO_RST;
      prev_first_r <= '0;
      at_start_r   <= 1'b1;
    end else begin
      prev_first_r <= prev_first_nxt;
      at_start_r   <= at_start_nxt;
      if (cfg_wr_en_i) begin
        unique case (lbzr_pkg::reg_idx_t'(cfg_index_i))
          lbzr_pkg::REG_FILTER_MODE:  mode_r   <= lbzr_pkg::mode_t'(cfg_wdata_i[0]);
          lbzr_pkg::REG_INPUT_SCALE:  scale_r  <= $signed(cfg_wdata_i);
          lbzr_pkg::REG_FEEDBACK_ONE: fb_one_r <= $signed(cfg_wdata_i);
          lbzr_pkg::REG_FEEDBACK_TWO: fb_two_r <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/lbzr_back.sv]
// Back part: runs the two-pole recursion, keeps the held output and drives
// the result register. Uses lbzr_pkg and lbzr_cmul.
`timescale 1ns / 1ps

module lbzr_back #(
  parameter int DATA_WIDTH     = lbzr_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = lbzr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   q_empty_i,
  input  lbzr_pkg::cmd_t                         head_cmd_i,
  input  logic signed [DATA_WIDTH-1:0]           head_value_i,
  output logic                                   pop_o,
  input  logic signed [lbzr_pkg::COEF_WIDTH-1:0] feedback_one_i,
  input  logic signed [lbzr_pkg::COEF_WIDTH-1:0] feedback_two_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [DATA_WIDTH-1:0]           out_data_o
);

  localparam int SW = DATA_WIDTH + 3;
  localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic signed [DATA_WIDTH-1:0] x1_r, x0_r, y1_r, y2_r;
  logic signed [DATA_WIDTH-1:0] held_r, held_nxt;
  logic signed [DATA_WIDTH-1:0] out_data_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] m_one, m_two, y_new;
  logic signed [SW-1:0]         sum;
  logic                         gives_result;
  logic                         lp_step;

  lbzr_cmul #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_fb_one (
    .data_i (y1_r),
    .coef_i (feedback_one_i),
    .prod_o (m_one)
  );

  lbzr_cmul #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_fb_two (
    .data_i (y2_r),
    .coef_i (feedback_two_i),
    .prod_o (m_two)
  );

  assign sum = SW'(x0_r) + (SW'(x1_r) <<< 1) + SW'(head_value_i) + SW'(m_one) + SW'(m_two);

  always_comb begin
    if (!sum[SW-1] && (|sum[SW-2:DATA_WIDTH-1])) begin
      y_new = DMAX;
    end else if (sum[SW-1] && !(&sum[SW-2:DATA_WIDTH-1])) begin
      y_new = DMIN;
    end else begin
      y_new = sum[DATA_WIDTH-1:0];
    end
  end

  assign gives_result = head_cmd_i.last || (head_cmd_i.op == lbzr_pkg::OP_EMPTY);
  assign pop_o        = !q_empty_i && (!gives_result || !out_valid_r || out_ready_i);
  assign lp_step      = pop_o && (head_cmd_i.op == lbzr_pkg::OP_LOWPASS);

  always_comb begin
    held_nxt = held_r;
    if (pop_o) begin
      case (head_cmd_i.op)
        lbzr_pkg::OP_LOWPASS:  held_nxt = y_new;
        lbzr_pkg::OP_HOLD_SET: held_nxt = head_value_i;
        default:               held_nxt = held_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r        <= '0;
      x0_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      if (lp_step) begin
        x0_r <= x1_r;
        x1_r <= head_value_i;
        y2_r <= y1_r;
        y1_r <= y_new;
      end
      if (pop_o && gives_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_o && gives_result) begin
      out_data_r <= held_nxt;
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

[sv/lowpass_biquad_or_zero_reject_filter_core.sv]
// Two-mode sensor filter core: two-pole low-pass or zero reject per batch.
// Top level; uses lbzr_pkg, lbzr_front, lbzr_queue and lbzr_back.
//
// Input channel in_*: one sensor sample per transaction; in_tlast ends a
// batch, in_tuser marks an empty batch (sample ignored). One result on out_*
// per batch end: last filtered value (low-pass), held start sample (zero
// reject) or held value (empty batch). Items ending no batch give none.
// cfg_*: write filter_mode (0), input_scale (1), feedback_one (2) and
// feedback_two (3) only while the block is idle; a mode write clears the
// stored first sample of zero-reject mode.
// Throughput: one sample per cycle while the queue is not full. The input
// product is formed in the front part, the feedback products and five-term
// sum combinationally in the back part, so the recursion closes through
// the y1/y2 history registers alone. A batch-ending item passes through the
// queue and out_tvalid is registered when the back part pops it. A two-entry
// queue decouples the parts: when out_tready is low the back part stops only
// at a result-giving item and in_tready falls once the queue is full.
// Reset (rst_n low, synchronous): histories and held output clear, registers
// take their default coefficients, the queue empties and out_tvalid falls.
`timescale 1ns / 1ps

module lowpass_biquad_or_zero_reject_filter_core #(
  parameter int DATA_WIDTH     = lbzr_pkg::DATA_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = lbzr_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]      in_tdata,  // sample
  input  logic                                 in_tlast,  // last_of_batch
  input  logic                                 in_tuser,  // empty_batch
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      out_tdata, // filtered
  input  logic                                 cfg_wr_en,
  input  logic [lbzr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lbzr_pkg::COEF_WIDTH-1:0]      cfg_wdata
);

  localparam int TW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int QW = $bits(lbzr_pkg::cmd_t) + DATA_WIDTH;

  logic                                   q_full, q_empty, push, pop;
  lbzr_pkg::cmd_t                         push_cmd, head_cmd;
  logic signed [DATA_WIDTH-1:0]           push_value, head_value, out_data;
  logic signed [lbzr_pkg::COEF_WIDTH-1:0] fb_one, fb_two;
  logic [QW-1:0]                          head_word;

  lbzr_front #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid_i     (in_tvalid),
    .in_ready_o     (in_tready),
    .sample_i       ($signed(in_tdata[DATA_WIDTH-1:0])),
    .last_i         (in_tlast),
    .empty_i        (in_tuser),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .q_full_i       (q_full),
    .push_o         (push),
    .push_cmd_o     (push_cmd),
    .push_value_o   (push_value),
    .feedback_one_o (fb_one),
    .feedback_two_o (fb_two)
  );

  lbzr_queue #(
    .WIDTH (QW),
    .DEPTH (lbzr_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i ({push_cmd, push_value}),
    .pop_i       (pop),
    .head_o      (head_word),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  assign head_cmd   = lbzr_pkg::cmd_t'(head_word[QW-1:DATA_WIDTH]);
  assign head_value = $signed(head_word[DATA_WIDTH-1:0]);

  lbzr_back #(
    .DATA_WIDTH     (DATA_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty_i      (q_empty),
    .head_cmd_i     (head_cmd),
    .head_value_i   (head_value),
    .pop_o          (pop),
    .feedback_one_i (fb_one),
    .feedback_two_i (fb_two),
    .out_valid_o    (out_tvalid),
    .out_ready_i    (out_tready),
    .out_data_o     (out_data)
  );

  assign out_tdata = TW'(unsigned'(out_data));

endmodule
